// File: hdl/rgb_luma_laplacian_3x3_unit_macros.svh
// assertion macros shared by the luma laplacian filter
`ifndef RGB_LUMA_LAPLACIAN_3X3_UNIT_MACROS_SVH
`define RGB_LUMA_LAPLACIAN_3X3_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RLL3_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rll3 same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define RLL3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rll3 next-cycle check failed");

`endif

// File: hdl/rll3_pkg.sv
// shared constants and types of the luma laplacian filter
package rll3_pkg;

  localparam int MAX_WIDTH_DEF = 64;

  localparam int PIX_W     = 24;
  localparam int LUMA_W    = 8;
  localparam int FW_W      = 7;
  localparam int FH_W      = 12;
  localparam int COL_OUT_W = 6;
  localparam int ROW_W     = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [FW_W-1:0] FW_RESET = 7'd64;
  localparam logic [FH_W-1:0] FH_RESET = 12'd48;
  localparam int              MIN_DIM  = 3;

  // luma weights, sum to 256
  localparam logic [7:0] K_RED   = 8'd77;
  localparam logic [7:0] K_GREEN = 8'd150;
  localparam logic [7:0] K_BLUE  = 8'd29;

  localparam logic [LUMA_W-1:0] LUMA_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// File: hdl/rll3_stream_if.sv
// valid/ready stream interfaces for pixel requests and filtered results
interface rll3_pixel_if import rll3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_rgb;

  modport source (output valid, output pixel_rgb, input ready);
  modport sink (input valid, input pixel_rgb, output ready);
endinterface

interface rll3_result_if import rll3_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_W-1:0]     out_row;
  logic [PIX_W-1:0]     gray_rgb;
  logic                 last_of_run;

  modport source (output valid, output out_col, output out_row, output gray_rgb,
                  output last_of_run, input ready);
  modport sink (input valid, input out_col, input out_row, input gray_rgb,
                input last_of_run, output ready);
endinterface

// File: hdl/rgb_luma_laplacian_3x3_unit.sv
// an accepted pixel passes stage one, then the result stage that offers its first result
// throughput: one pixel per cycle while results are taken and each yields at most one
// a pixel closing a row below the first or on the last row past column zero yields
// two or three results and holds the input while they leave the single result port
// reset clears counters, window, stage valids and sets width 64, height 48
// line buffers are not cleared and need no clearing pass
`include "rgb_luma_laplacian_3x3_unit_macros.svh"

module rgb_luma_laplacian_3x3_unit import rll3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rll3_pixel_if.sink            pixels,
  rll3_result_if.source         results
);

  localparam int AW = $clog2(MAX_WIDTH);

  // result flags worked out when the pixel is taken
  typedef struct packed {
    logic e0;      // filtered pixel one row up, one column left
    logic e1;      // right border pixel of the row above
    logic e2;      // bottom border pixel at this position on the last row
    logic lap_ok;  // window fully inside the frame
  } flags_t;

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  always_comb begin
    if (int'(frame_width) < MIN_DIM) begin
      w_eff = FW_W'(MIN_DIM);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (int'(frame_height) < MIN_DIM) begin
      h_eff = FH_W'(MIN_DIM);
    end else begin
      h_eff = frame_height;
    end
  end

  // raster position counters
  logic [FW_W-1:0]  col;
  logic [ROW_W-1:0] row;

  logic             in_acc;
  logic             col_wrap;
  logic [ROW_W:0]   row_pre;
  logic [FW_W-1:0]  cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [FW_W:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic             row_end;
  logic [FW_W-1:0]  col_next;
  logic [ROW_W-1:0] row_next;
  flags_t           cur_flags;

  assign in_acc = pixels.valid && pixels.ready;

  always_comb begin
    // a size change between frames may leave the counters out of range
    col_wrap = col >= w_eff;
    row_pre  = col_wrap ? ({1'b0, row} + 13'd1) : {1'b0, row};
    cur_col  = col_wrap ? '0 : col;
    cur_row  = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[ROW_W-1:0];

    col_inc  = {1'b0, cur_col} + 8'd1;
    row_inc  = {1'b0, cur_row} + 13'd1;
    row_end  = col_inc >= {1'b0, w_eff};
    col_next = row_end ? '0 : col_inc[FW_W-1:0];
    if (row_end) begin
      row_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      row_next = cur_row;
    end

    cur_flags.e0     = (cur_row != '0) && (cur_col != '0);
    cur_flags.e1     = (cur_row != '0) && (cur_col == w_eff - 7'd1);
    cur_flags.e2     = cur_row == h_eff - 12'd1;
    cur_flags.lap_ok = (cur_col >= 7'd2) && (cur_row >= 12'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // luma of the incoming pixel, weights sum to 256
  logic [15:0]       luma_sum;
  logic [LUMA_W-1:0] cur_luma;

  assign luma_sum = {8'b0, pixels.pixel_rgb[23:16]} * {8'b0, K_RED}
                  + {8'b0, pixels.pixel_rgb[15:8]}  * {8'b0, K_GREEN}
                  + {8'b0, pixels.pixel_rgb[7:0]}   * {8'b0, K_BLUE};
  assign cur_luma = luma_sum[15:8];

  // stage one: pixel luma, position and flags, line buffer read lands here
  logic              s1_valid;
  logic [FW_W-1:0]   s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [LUMA_W-1:0] s1_luma;
  flags_t            s1_flags;
  logic              s1_adv;
  logic [LUMA_W-1:0] top_luma;
  logic [LUMA_W-1:0] mid_luma;

  // line buffer write happens as the pixel leaves stage one; the next read
  // always hits another column since a row is at least three wide
  rll3_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (AW'(cur_col)),
    .wr_en    (s1_adv),
    .wr_addr  (AW'(s1_col)),
    .wr_older (mid_luma),
    .wr_newer (s1_luma),
    .rd_older (top_luma),
    .rd_newer (mid_luma)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col   <= cur_col;
      s1_row   <= cur_row;
      s1_luma  <= cur_luma;
      s1_flags <= cur_flags;
    end
  end

  // 3x3 window: two older columns kept per row, newest column is the read data and the stage-one luma
  logic [LUMA_W-1:0] win_t1, win_t2, win_m1, win_m2, win_b1, win_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_t1 <= '0;
      win_t2 <= '0;
      win_m1 <= '0;
      win_m2 <= '0;
      win_b1 <= '0;
      win_b2 <= '0;
    end else if (s1_adv) begin
      win_t1 <= win_t2;
      win_t2 <= top_luma;
      win_m1 <= win_m2;
      win_m2 <= mid_luma;
      win_b1 <= win_b2;
      win_b2 <= s1_luma;
    end
  end

  // laplacian on the shifted window: centre is the old middle-row newest tap
  logic [10:0]       nb_sum;
  logic [10:0]       centre8;
  logic [10:0]       lap_diff;
  logic [LUMA_W-1:0] lap_val;
  logic [LUMA_W-1:0] s1_val;

  always_comb begin
    nb_sum   = 11'(win_t1) + 11'(win_t2) + 11'(top_luma)
             + 11'(win_m1) + 11'(mid_luma)
             + 11'(win_b1) + 11'(win_b2) + 11'(s1_luma);
    centre8  = {win_m2, 3'b000};
    lap_diff = centre8 - nb_sum;
    if (nb_sum > centre8) begin
      lap_val = '0;
    end else if (lap_diff > 11'(LUMA_MAX)) begin
      lap_val = LUMA_MAX;
    end else begin
      lap_val = lap_diff[LUMA_W-1:0];
    end
    s1_val = s1_flags.lap_ok ? lap_val : '0;
  end

  // stage two: up to three pending results of one pixel, lowest bit first
  logic [2:0]        res_pend;
  logic [FW_W-1:0]   res_col;
  logic [ROW_W-1:0]  res_row;
  logic [LUMA_W-1:0] res_val;
  logic              res_acc;
  logic              res_single;
  logic              s2_free;

  assign res_acc    = results.valid && results.ready;
  assign res_single = (res_pend & (res_pend - 3'd1)) == 3'd0;
  // the result stage is empty or empties this cycle, so a new pixel may move in
  assign s2_free    = (res_pend == 3'd0) || (res_single && res_acc);
  assign s1_adv     = s1_valid && s2_free;
  assign pixels.ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend <= '0;
    end else if (s1_adv) begin
      res_pend <= {s1_flags.e2, s1_flags.e1, s1_flags.e0};
    end else if (res_acc) begin
      res_pend <= res_pend & (res_pend - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_col <= s1_col;
      res_row <= s1_row;
      res_val <= s1_val;
    end
  end

  // result select: filtered pixel, right border of row above, bottom border
  logic [FW_W-1:0]   sel_col;
  logic [ROW_W-1:0]  sel_row;
  logic [LUMA_W-1:0] sel_val;

  always_comb begin
    if (res_pend[0]) begin
      sel_col = res_col - 7'd1;
      sel_row = res_row - 12'd1;
      sel_val = res_val;
    end else if (res_pend[1]) begin
      sel_col = res_col;
      sel_row = res_row - 12'd1;
      sel_val = '0;
    end else begin
      sel_col = res_col;
      sel_row = res_row;
      sel_val = '0;
    end
  end

  assign results.valid       = res_pend != 3'd0;
  assign results.out_col     = sel_col[COL_OUT_W-1:0];
  assign results.out_row     = sel_row;
  assign results.gray_rgb    = {sel_val, sel_val, sel_val};
  assign results.last_of_run = res_single;

  // checks
  `RLL3_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_col) && $stable(s1_luma))
  `RLL3_ASSERT_NEXT(a_res_hold, results.valid && !results.ready, $stable(res_pend) && $stable(res_val))
  `RLL3_ASSERT_SAME(a_edge_implies_filtered, s1_valid && s1_flags.e1, s1_flags.e0)
  `RLL3_ASSERT_SAME(a_nonzero_is_filtered, results.valid && (results.gray_rgb != '0), res_pend[0])

endmodule

// File: hdl/rll3_line_buffer.sv
// two row memories of luma with registered read and one write port each
module rll3_line_buffer import rll3_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LUMA_W-1:0] wr_older,
  input  logic [LUMA_W-1:0] wr_newer,
  output logic [LUMA_W-1:0] rd_older,
  output logic [LUMA_W-1:0] rd_newer
);

  logic [LUMA_W-1:0] older_mem [DEPTH];
  logic [LUMA_W-1:0] newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_older <= older_mem[rd_addr];
      rd_newer <= newer_mem[rd_addr];
    end
  end

endmodule
